// ===== rtl/centered_window_average_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the centred window average unit
// Assertions sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CENTERED_WINDOW_AVERAGE_UNIT_MACROS_SVH
`define CENTERED_WINDOW_AVERAGE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CWA_ASSERT_CLK(label, ck, rstn, prop) \
  label: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("cwa: assertion failed");

`define CWA_ASSERT(label, prop) `CWA_ASSERT_CLK(label, clk, rst_n, prop)

`else

`define CWA_ASSERT_CLK(label, ck, rstn, prop)

`define CWA_ASSERT(label, prop)

`endif

`endif

// ===== rtl/cwa_pkg.sv =====
// ---------------------------------------------------------------------------
// cwa_pkg
// Types and constants shared by the centred window average unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwa_pkg;

  localparam int RADIUS_BITS     = 6;
  localparam int FIELD_BITS      = 32;
  localparam int DEF_MAX_RADIUS  = 63;
  localparam int DEF_SAMPLE_BITS = 32;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] sample;
    logic                         final_sample;
  } cwa_in_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] average;
    logic                         full_window;
    logic                         end_of_run;
  } cwa_out_t;

endpackage

`default_nettype wire

// ===== rtl/cwa_ram.sv =====
// ---------------------------------------------------------------------------
// cwa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/cwa_div.sv =====
// ---------------------------------------------------------------------------
// cwa_div
// Bit-serial signed by unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwa_div #(
  parameter int DIVIDEND_BITS = 39,
  parameter int DIVISOR_BITS  = 7,
  parameter int QUOT_BITS     = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic signed [DIVIDEND_BITS-1:0] dividend,
  input  wire logic        [DIVISOR_BITS-1:0]  divisor,
  output logic                                 done,
  output logic signed      [QUOT_BITS-1:0]     quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic [DIVIDEND_BITS-1:0]  mag_r, mag_nxt;
  logic [DIVISOR_BITS-1:0]   rem_r, rem_nxt;
  logic                      neg_r, neg_nxt;
  logic [DIVISOR_BITS:0]     trial;
  logic                      q_bit;
  logic [DIVIDEND_BITS-1:0]  signed_q;

  assign trial = {rem_r, mag_r[DIVIDEND_BITS-1]};
  assign q_bit = (trial >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(DIVIDEND_BITS);
      neg_nxt  = dividend[DIVIDEND_BITS-1];
      mag_nxt  = dividend[DIVIDEND_BITS-1] ? -dividend : dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // restoring step: quotient bits shift in behind the dividend
      rem_nxt = q_bit ? DIVISOR_BITS'(trial - {1'b0, divisor})
                      : trial[DIVISOR_BITS-1:0];
      mag_nxt = {mag_r[DIVIDEND_BITS-2:0], q_bit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign signed_q = neg_r ? -mag_r : mag_r;
  assign quotient = signed_q[QUOT_BITS-1:0];
  assign done     = done_r;

endmodule

`default_nettype wire

// ===== rtl/centered_window_average_unit.sv =====
// ---------------------------------------------------------------------------
// centered_window_average_unit
// Centred moving average over a signed sample stream, window 2k+1, with
// padding results for positions lacking a full window.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+------------------------------------
//   in_     | in  | valid / stall   | sample, final_sample
//   out_    | out | valid / stall   | average, full_window, end_of_run
//   cfg_    | in  | valid / ready   | radius (6 bits)
//
// A full-window item passes through ACC, START, DIV and EMIT, its average
// computed by the bit-serial divider; a padding item passes through ACC and
// EMIT, and an early item with no result through ACC only. Trailing padding
// after the final item goes out at one per cycle while out_stall is low.
// Reset is synchronous and needs no clearing pass: ring entries are always
// written before they are read. The result register lets a new item in
// while the last result is still stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module centered_window_average_unit #(
  parameter int MAX_RADIUS  = cwa_pkg::DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS = cwa_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire cwa_pkg::cwa_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output cwa_pkg::cwa_out_t                   out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cwa_pkg::RADIUS_BITS-1:0] cfg_data
);

  import cwa_pkg::*;

`include "centered_window_average_unit_macros.svh"

  localparam int W_BITS     = $clog2(2 * MAX_RADIUS + 2);
  localparam int RING_DEPTH = 1 << W_BITS;
  localparam int SUM_BITS   = SAMPLE_BITS + W_BITS;
  localparam logic [W_BITS-1:0] SEEN_MAX = '1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ACC   = 6'b000010,
    ST_START = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_TRAIL = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [RADIUS_BITS-1:0]         radius_r, radius_nxt;
  logic [RADIUS_BITS-1:0]         k_r, k_nxt;
  logic signed [SAMPLE_BITS-1:0]  x_r, x_nxt;
  logic                           last_r, last_nxt;
  logic signed [SUM_BITS-1:0]     sum_r, sum_nxt;
  logic [W_BITS-1:0]              seen_r, seen_nxt;
  logic [W_BITS-1:0]              ptr_r, ptr_nxt;
  logic [RADIUS_BITS-1:0]         trail_r, trail_nxt;
  logic signed [SAMPLE_BITS-1:0]  res_avg_r, res_avg_nxt;
  logic                           res_full_r, res_full_nxt;
  logic                           out_valid_r, out_valid_nxt;
  cwa_out_t                       out_data_r, out_data_nxt;

  logic [RADIUS_BITS-1:0]         radius_clamped;
  logic [RADIUS_BITS-1:0]         k_cur;
  logic [W_BITS-1:0]              w_cur;
  logic [W_BITS-1:0]              w_r;
  logic [W_BITS-1:0]              seen_inc;
  logic                           in_acc;
  logic                           out_free;
  logic                           out_load;
  logic                           ram_we;
  logic [W_BITS-1:0]              ram_raddr;
  logic [SAMPLE_BITS-1:0]         ram_rdata;
  logic signed [SAMPLE_BITS-1:0]  x_in;
  logic signed [SAMPLE_BITS-1:0]  old_x;
  logic                           div_start;
  logic                           div_done;
  logic signed [SAMPLE_BITS-1:0]  div_q;

  assign x_in   = signed'(in_data.sample[SAMPLE_BITS-1:0]);
  assign in_acc = in_valid && !in_stall;

  // radius is latched at the first item of each sequence
  assign radius_clamped = (radius_r > RADIUS_BITS'(MAX_RADIUS)) ? RADIUS_BITS'(MAX_RADIUS)
                                                                : radius_r;
  assign k_cur     = (seen_r == '0) ? radius_clamped : k_r;
  assign w_cur     = W_BITS'({k_cur, 1'b1});
  assign w_r       = W_BITS'({k_r, 1'b1});
  assign seen_inc  = (seen_r != SEEN_MAX) ? seen_r + 1'b1 : seen_r;
  assign ram_we    = in_acc;
  assign ram_raddr = ptr_r - w_cur;
  assign old_x     = signed'(ram_rdata);
  assign out_free  = !out_valid_r || !out_stall;
  assign div_start = (state_r == ST_START);

  cwa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ptr_r),
    .wr_data (x_in),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  cwa_div #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (W_BITS),
    .QUOT_BITS     (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (w_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    radius_nxt    = radius_r;
    k_nxt         = k_r;
    x_nxt         = x_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    seen_nxt      = seen_r;
    ptr_nxt       = ptr_r;
    trail_nxt     = trail_r;
    res_avg_nxt   = res_avg_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_load      = 1'b0;

    if (cfg_valid) begin
      radius_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          k_nxt     = k_cur;
          x_nxt     = x_in;
          last_nxt  = in_data.final_sample;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        // ring read of the sample leaving the window lands this cycle
        sum_nxt  = sum_r + SUM_BITS'(x_r)
                 - ((seen_r >= w_r) ? SUM_BITS'(old_x) : SUM_BITS'(0));
        ptr_nxt  = ptr_r + 1'b1;
        seen_nxt = seen_inc;
        if (7'(seen_inc) > 7'(k_r)) begin
          trail_nxt = k_r;
          if (seen_inc >= w_r) begin
            state_nxt = ST_START;
          end else begin
            res_avg_nxt  = '1;
            res_full_nxt = 1'b0;
            state_nxt    = ST_EMIT;
          end
        end else if (last_r) begin
          trail_nxt = RADIUS_BITS'(seen_inc);
          state_nxt = ST_TRAIL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_avg_nxt  = div_q;
          res_full_nxt = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.average     = FIELD_BITS'(res_avg_r);
          out_data_nxt.full_window = res_full_r;
          out_data_nxt.end_of_run  = last_r && (trail_r == '0);
          if (last_r && (trail_r != '0)) begin
            state_nxt = ST_TRAIL;
          end else begin
            state_nxt = ST_IDLE;
            if (last_r) begin
              sum_nxt  = '0;
              seen_nxt = '0;
              ptr_nxt  = '0;
            end
          end
        end
      end
      ST_TRAIL: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.average     = '1;
          out_data_nxt.full_window = 1'b0;
          out_data_nxt.end_of_run  = (trail_r == RADIUS_BITS'(1));
          trail_nxt                = trail_r - 1'b1;
          if (trail_r == RADIUS_BITS'(1)) begin
            state_nxt = ST_IDLE;
            sum_nxt   = '0;
            seen_nxt  = '0;
            ptr_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= '0;
      k_r         <= '0;
      sum_r       <= '0;
      seen_r      <= '0;
      ptr_r       <= '0;
      trail_r     <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      k_r         <= k_nxt;
      sum_r       <= sum_nxt;
      seen_r      <= seen_nxt;
      ptr_r       <= ptr_nxt;
      trail_r     <= trail_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    res_avg_r  <= res_avg_nxt;
    res_full_r <= res_full_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider only finishes while the sequencer waits on it
  `CWA_ASSERT(a_div_done_in_div, div_done |-> state_r == ST_DIV)

  // a trailing run never starts or continues with an empty count
  `CWA_ASSERT(a_trail_nonzero, state_r == ST_TRAIL |-> trail_r != '0)

  // a full-window result only once the window has filled
  `CWA_ASSERT(a_full_needs_window,
    (out_load && out_data_nxt.full_window) |-> seen_r >= w_r)

  // end of run leaves the sequence state cleared
  `CWA_ASSERT(a_eor_clears,
    (out_load && out_data_nxt.end_of_run) |=> (seen_r == '0 && ptr_r == '0 && sum_r == '0))

endmodule

`default_nettype wire
